// ===== rtl/core/lwr_pkg.sv =====
// Package with the shared constants, types and divider step of the luma watermark remover.
package lwr_pkg;

  // Field and register widths.
  localparam int unsigned LumaW = 8;
  localparam int unsigned CfgW  = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned RemW  = 10;
  localparam int unsigned DivW  = 17;

  // Video levels and register reset values.
  localparam logic [LumaW-1:0] LumaFull    = 8'd255;
  localparam logic [LumaW-1:0] NormSpan    = 8'd224;
  localparam logic [LumaW-1:0] LumaFloor   = 8'd16;
  localparam logic [LumaW-1:0] LumaCeil    = 8'd240;
  localparam logic [LumaW-1:0] BrightReset = 8'd128;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgBright  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaskDiv = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBlack   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgWhite   = 2'd3;

  // Sideband that travels with an item through a divider pipeline.
  typedef struct packed {
    logic [LumaW-1:0] luma;     // input luma, used around the mask divider
    logic [LumaW-1:0] bypass;   // clamped result when normalization is off
    logic             neg;      // normalized numerator is negative
    logic             norm;     // normalization is enabled
  } lwr_side_t;

  // Partial remainder and dividend/quotient shift word of one divider stage.
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DivW-1:0] acc;
  } div_state_t;

  // One restoring division step: bring down the next dividend bit and
  // subtract the divisor when it fits, shifting the quotient bit in.
  function automatic div_state_t div_step(div_state_t cur, logic [RemW-1:0] divisor);
    logic [RemW:0] trial;
    logic [RemW:0] diff;
    div_state_t    nxt;
    trial = {cur.rem, cur.acc[DivW-1]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      nxt.rem = diff[RemW-1:0];
      nxt.acc = {cur.acc[DivW-2:0], 1'b1};
    end else begin
      nxt.rem = trial[RemW-1:0];
      nxt.acc = {cur.acc[DivW-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

// ===== rtl/core/lwr_if.sv =====
// Valid/ready channel interfaces for the luma samples going in and out.
interface lwr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_in;
  logic [7:0] mask_value;

  modport source (output valid, output luma_in, output mask_value, input ready);
  modport sink (input valid, input luma_in, input mask_value, output ready);
endinterface

interface lwr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_out;

  modport source (output valid, output luma_out, input ready);
  modport sink (input valid, input luma_out, output ready);
endinterface

// ===== rtl/core/lwr_div_pipe.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
module lwr_div_pipe (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [lwr_pkg::DivW-1:0]   dividend_i,
  input  logic [lwr_pkg::RemW-1:0]   divisor_i,
  input  lwr_pkg::lwr_side_t         side_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [lwr_pkg::DivW-1:0]   quotient_o,
  output lwr_pkg::lwr_side_t         side_o
);
  import lwr_pkg::*;

  logic       [DivW-1:0] valid_q;
  div_state_t            state_q [DivW];
  lwr_side_t             side_q  [DivW];
  logic       [DivW:0]   rdy;

  // A stage takes new data when it is empty or its successor moves on.
  assign rdy[DivW] = out_ready_i;

  for (genvar k = 0; k < DivW; k++) begin : g_stage
    logic       prev_valid;
    div_state_t prev_state;
    lwr_side_t  prev_side;

    if (k == 0) begin : g_first
      assign prev_valid     = in_valid_i;
      assign prev_state.rem = '0;
      assign prev_state.acc = dividend_i;
      assign prev_side      = side_i;
    end else begin : g_next
      assign prev_valid = valid_q[k-1];
      assign prev_state = state_q[k-1];
      assign prev_side  = side_q[k-1];
    end

    assign rdy[k] = !valid_q[k] || rdy[k+1];

    // Valid bit of the stage.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= prev_valid;
      end
    end

    // Division step and sideband of the stage.
    always_ff @(posedge clk_i) begin
      if (rdy[k] && prev_valid) begin
        state_q[k] <= div_step(prev_state, divisor_i);
        side_q[k]  <= prev_side;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[DivW-1];
  assign quotient_o  = state_q[DivW-1].acc;
  assign side_o      = side_q[DivW-1];

endmodule

// ===== rtl/core/luma_watermark_remover_unit.sv =====
// Top level of the luma watermark remover: configuration registers and the pixel pipeline.
// The unit takes one luma sample and its mask value per clock while it is not stalled, and
// returns one corrected, clamped luma sample per item, in order. From acceptance to the
// output an item passes the registered mask product, the mask divider, the brightness
// and normalization setup stages B and C, the normalization divider and the final clamp
// register, in that order. The two dividers are 17-stage restoring pipelines that
// produce one quotient bit per stage, so a new item enters every clock while no stall
// holds the input, and a stall at the output only holds the stages that are full. The
// stages read the registers directly, so write them only while no item is in flight; a
// mask divisor of zero acts as one.
module luma_watermark_remover_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lwr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lwr_pkg::CfgW-1:0]      cfg_data_i,
  lwr_in_if.sink                        in_i,
  lwr_out_if.source                     out_o
);
  import lwr_pkg::*;

  // Configuration registers.
  logic [LumaW-1:0] bright_q;
  logic [CfgW-1:0]  mask_div_q;
  logic [CfgW-1:0]  black_q;
  logic [CfgW-1:0]  white_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q   <= BrightReset;
      mask_div_q <= CfgW'(NormSpan);
      black_q    <= '0;
      white_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBright:  bright_q   <= cfg_data_i[LumaW-1:0];
        CfgMaskDiv: mask_div_q <= cfg_data_i;
        CfgBlack:   black_q    <= cfg_data_i;
        CfgWhite:   white_q    <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Derived divisors and the normalization switch.
  logic [RemW-1:0] mask_div_eff;
  logic [RemW-1:0] span;
  logic            norm_en;

  assign mask_div_eff = (mask_div_q == '0) ? RemW'(1) : mask_div_q;
  assign span         = white_q - black_q;
  assign norm_en      = white_q > black_q;

  // Stage A: mask-weighted inverse luma.
  logic             a_valid_q;
  logic             a_rdy;
  logic [15:0]      a_prod_q;
  logic [LumaW-1:0] a_luma_q;
  logic             div1_in_ready;

  assign a_rdy    = !a_valid_q || div1_in_ready;
  assign in_i.ready = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_rdy) begin
      a_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_i.valid) begin
      a_prod_q <= (LumaFull - in_i.luma_in) * in_i.mask_value;
      a_luma_q <= in_i.luma_in;
    end
  end

  // Mask divider.
  lwr_side_t       div1_side_in;
  lwr_side_t       div1_side_out;
  logic            div1_out_valid;
  logic [DivW-1:0] div1_quo;
  logic            b_rdy;

  always_comb begin
    div1_side_in        = '0;
    div1_side_in.luma   = a_luma_q;
  end

  lwr_div_pipe u_mask_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_valid_q),
    .in_ready_o  (div1_in_ready),
    .dividend_i  ({1'b0, a_prod_q}),
    .divisor_i   (mask_div_eff),
    .side_i      (div1_side_in),
    .out_valid_o (div1_out_valid),
    .out_ready_i (b_rdy),
    .quotient_o  (div1_quo),
    .side_o      (div1_side_out)
  );

  // Stage B: brightness offset minus the mask term.
  logic               b_valid_q;
  logic signed [17:0] b_v_q;
  logic               c_rdy;

  assign b_rdy = !b_valid_q || c_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_rdy) begin
      b_valid_q <= div1_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_rdy && div1_out_valid) begin
      b_v_q <= $signed({10'd0, div1_side_out.luma}) + $signed({10'd0, bright_q})
             - $signed({1'b0, div1_quo});
    end
  end

  // Stage C: black level removal, scaling numerator and the plain clamp.
  logic               c_valid_q;
  logic [DivW-1:0]    c_num_q;
  lwr_side_t          c_side_q;
  logic signed [17:0] c_t;
  logic [8:0]         c_t9;
  logic [LumaW-1:0]   c_byp;
  logic               div2_in_ready;

  assign c_rdy = !c_valid_q || div2_in_ready;
  assign c_t   = b_v_q - $signed({8'd0, black_q});
  assign c_t9  = c_t[8:0];

  always_comb begin
    if (b_v_q > $signed({10'd0, LumaCeil})) begin
      c_byp = LumaCeil;
    end else if (b_v_q < $signed({10'd0, LumaFloor})) begin
      c_byp = LumaFloor;
    end else begin
      c_byp = b_v_q[LumaW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_rdy) begin
      c_valid_q <= b_valid_q;
    end
  end

  // The scaled numerator is t * 224 = t * 256 - t * 32; only used when t is not negative.
  always_ff @(posedge clk_i) begin
    if (c_rdy && b_valid_q) begin
      c_num_q         <= {c_t9, 8'd0} - {3'd0, c_t9, 5'd0};
      c_side_q.luma   <= '0;
      c_side_q.bypass <= c_byp;
      c_side_q.neg    <= c_t[17];
      c_side_q.norm   <= norm_en;
    end
  end

  // Normalization divider.
  lwr_side_t       div2_side_out;
  logic            div2_out_valid;
  logic [DivW-1:0] div2_quo;
  logic            d_rdy;

  lwr_div_pipe u_norm_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (c_valid_q),
    .in_ready_o  (div2_in_ready),
    .dividend_i  (c_num_q),
    .divisor_i   (span),
    .side_i      (c_side_q),
    .out_valid_o (div2_out_valid),
    .out_ready_i (d_rdy),
    .quotient_o  (div2_quo),
    .side_o      (div2_side_out)
  );

  // Stage D: offset, final clamp and output register.
  logic             out_valid_q;
  logic [LumaW-1:0] luma_out_q;
  logic [LumaW-1:0] d_luma;

  assign d_rdy = !out_valid_q || out_o.ready;

  always_comb begin
    if (!div2_side_out.norm) begin
      d_luma = div2_side_out.bypass;
    end else if (div2_side_out.neg) begin
      d_luma = LumaFloor;
    end else if (div2_quo >= DivW'(NormSpan)) begin
      d_luma = LumaCeil;
    end else begin
      d_luma = div2_quo[LumaW-1:0] + LumaFloor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (d_rdy) begin
      out_valid_q <= div2_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_rdy && div2_out_valid) begin
      luma_out_q <= d_luma;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.luma_out = luma_out_q;

  // Every delivered sample lies in the video range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.luma_out >= LumaFloor) && (out_o.luma_out <= LumaCeil))
    else $error("luma_out outside the video range");

  // An accepted item lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> a_valid_q)
    else $error("accepted item lost at the first stage");

  // The input is only held off while the first stage is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> a_valid_q)
    else $error("input stalled with an empty first stage");

  // A held result keeps its value while the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(luma_out_q) && out_valid_q)
    else $error("stalled result changed");

endmodule
